// ===== rtl/brbe_pkg.sv =====
`timescale 1ns / 1ps
package brbe_pkg;

  typedef enum logic [1:0] {
    OPN_PROG  = 2'd0,
    OPN_ADD   = 2'd1,
    OPN_CLEAR = 2'd2,
    OPN_NONE  = 2'd3
  } opn_e;

  typedef enum logic [2:0] {
    OPC_API   = 3'd0,
    OPC_UNK   = 3'd1,
    OPC_TRUE  = 3'd2,
    OPC_FALSE = 3'd3,
    OPC_NOT   = 3'd4,
    OPC_AND   = 3'd5,
    OPC_OR    = 3'd6,
    OPC_NOF   = 3'd7
  } opc_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_TRUNC = 3'd1,
    ST_UNDER = 3'd2,
    ST_BADOP = 3'd3,
    ST_OVER  = 3'd4,
    ST_DEPTH = 3'd5
  } status_e;

  localparam logic [3:0] REG_UNKNOWN_VALUE = 4'd0;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  program_byte;
    logic        last_byte;
    logic [31:0] api_id;
  } in_item_t;

  typedef struct packed {
    logic       match;
    logic [2:0] status;
  } out_item_t;

  // Operand length in bytes for each opcode.
  function automatic logic [2:0] operand_len(logic [2:0] opc);
    logic [2:0] len;
    len = 3'd0;
    if (opc == OPC_API || opc == OPC_NOF) len = 3'd4;
    else if (opc == OPC_AND || opc == OPC_OR) len = 3'd2;
    return len;
  endfunction

endpackage

// ===== rtl/brbe_if.sv =====
`timescale 1ns / 1ps
interface brbe_in_if;
  logic               valid;
  logic               ready;
  brbe_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface brbe_out_if;
  logic                valid;
  logic                ready;
  brbe_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/brbe_present.sv =====
`timescale 1ns / 1ps
module brbe_present #(
  parameter int unsigned PresentEntries = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        add_i,
  input  logic        clear_i,
  input  logic [31:0] add_id_i,
  input  logic        search_i,
  input  logic [31:0] search_id_i,
  output logic        busy_o,
  output logic        done_o,
  output logic        found_o
);
  import brbe_pkg::*;

  localparam int unsigned AW = (PresentEntries > 1) ? $clog2(PresentEntries) : 1;
  localparam int unsigned CW = $clog2(PresentEntries + 1);
  localparam logic [CW-1:0] Full = CW'(PresentEntries);

  logic [31:0]   mem [PresentEntries];
  logic [31:0]   rdata_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          run_q, run_d, chk_q, chk_d, found_q, found_d, done_q, done_d;
  logic [31:0]   key_q;

  // Table storage: one write, one registered read.
  always_ff @(posedge clk_i) begin
    if (add_i && count_q < Full) mem[count_q[AW-1:0]] <= add_id_i;
    rdata_q <= mem[idx_q[AW-1:0]];
    if (search_i) key_q <= search_id_i;
  end

  // Sequential scan: issue a read per cycle, compare the registered data.
  always_comb begin
    count_d = count_q;
    if (clear_i) count_d = '0;
    else if (add_i && count_q < Full) count_d = count_q + 1'b1;
    idx_d = idx_q;
    run_d = run_q;
    chk_d = 1'b0;
    found_d = found_q;
    done_d = 1'b0;
    if (search_i) begin
      idx_d = '0;
      run_d = 1'b1;
      found_d = 1'b0;
    end else begin
      if (chk_q && rdata_q == key_q) found_d = 1'b1;
      if (run_q) begin
        if (idx_q >= count_q) begin
          run_d = 1'b0;
          done_d = 1'b1;
        end else begin
          chk_d = 1'b1;
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q <= '0;
      run_q <= 1'b0;
      chk_q <= 1'b0;
      found_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q <= idx_d;
      run_q <= run_d;
      chk_q <= chk_d;
      found_q <= found_d;
      done_q <= done_d;
    end
  end

  // The last compare happens in the cycle that ends the scan, so found_o is final with done_o.
  assign busy_o = run_q | done_q;
  assign done_o = done_q;
  assign found_o = found_q;
endmodule

// ===== rtl/boolean_rule_bytecode_evaluator.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Payload                                        Handshake
// in       in   operation, program_byte, last_byte, api_id     valid/ready
// out      out  match, status                                  valid/ready
// cfg      in   unknown_value at address 0                     APB, pready high
//
// Every transaction is accepted in the idle state. After that cycle, a push opcode
// passes a write state and a finish state; NOT adds an address setup step before its
// write-back. An API lookup scans the present table one entry per cycle, then pushes.
// A reduction reads the stack memory one bit per cycle, then pushes. Table operations
// and bytes that start no step and end no program stay idle. Reset clears all control
// state; stack and table contents are undefined. A result waits in the output register;
// only the next last byte stalls on it.
module boolean_rule_bytecode_evaluator #(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned PRESENT_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  brbe_in_if.sink     in_i,
  brbe_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import brbe_pkg::*;

  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
  localparam logic [LW-1:0] Depth = LW'(STACK_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOOK = 6'b000010,
    S_RED  = 6'b000100,
    S_PUSH = 6'b001000,
    S_NOTR = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  logic          unk_q;
  logic [LW-1:0] level_q, level_d;
  logic [2:0]    pend_q, pend_d;
  logic [2:0]    left_q, left_d;
  logic [31:0]   gather_q, gather_d;
  logic [2:0]    err_q, err_d;
  logic          last_q, last_d;
  logic          pbit_q, pbit_d;
  logic [16:0]   cnt_q, cnt_d;
  logic [16:0]   ones_q, ones_d;
  logic          rdv_q, rdv_d;
  logic          ov_q, ov_d;
  out_item_t     res_q, res_d;

  // Stack memory.
  logic          stk [STACK_DEPTH];
  logic          swe, swd, srd_q;
  logic [SAW-1:0] swa, sra;
  logic          bot_q;

  always_ff @(posedge clk_i) begin
    if (swe) stk[swa] <= swd;
    srd_q <= stk[sra];
    if (swe && swa == '0) bot_q <= swd;
  end

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = {31'd0, unk_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) unk_q <= 1'b0;
    else if (psel && penable && pwrite && paddr == REG_UNKNOWN_VALUE[1:0]) unk_q <= pwdata[0];
  end

  // Present table.
  logic acc, lk_start, lk_busy, lk_done, lk_found;
  logic [31:0] arg;
  assign acc = in_i.valid && in_i.ready;
  brbe_present #(.PresentEntries(PRESENT_ENTRIES)) u_present (
    .clk_i, .rst_ni,
    .add_i(acc && in_i.data.operation == OPN_ADD),
    .clear_i(acc && in_i.data.operation == OPN_CLEAR),
    .add_id_i(in_i.data.api_id),
    .search_i(lk_start), .search_id_i(arg),
    .busy_o(lk_busy), .done_o(lk_done), .found_o(lk_found)
  );

  assign in_i.ready = (state_q == S_IDLE) &&
    !(out_o.valid && in_i.data.last_byte && in_i.data.operation == OPN_PROG);
  assign out_o.data = res_q;

  logic [7:0]  b;
  logic [31:0] g2;
  logic [2:0]  pos;
  logic [15:0] n16, k16;
  logic        fin;

  always_comb begin
    b = in_i.data.program_byte;
    pos = operand_len(pend_q) - left_q;
    g2 = gather_q | ({24'd0, b} << {pos[1:0], 3'b000});
    arg = g2;
    k16 = (pend_q == OPC_NOF) ? gather_q[15:0] : 16'd0;
    n16 = (pend_q == OPC_NOF) ? gather_q[31:16] : gather_q[15:0];
    state_d = state_q; level_d = level_q; pend_d = pend_q; left_d = left_q;
    gather_d = gather_q; err_d = err_q; last_d = last_q; pbit_d = pbit_q;
    cnt_d = cnt_q; ones_d = ones_q; rdv_d = 1'b0; ov_d = 1'b0;
    res_d = res_q; lk_start = 1'b0; fin = 1'b0;
    swe = 1'b0; swd = 1'b0;
    swa = level_q[SAW-1:0];
    sra = SAW'(level_q - 1'b1);
    unique case (state_q)
      S_IDLE: begin
        if (acc && in_i.data.operation == OPN_PROG) begin
          last_d = in_i.data.last_byte;
          state_d = S_DONE;
          if (err_q == ST_OK) begin
            if (left_q != 3'd0) begin
              gather_d = g2;
              left_d = left_q - 1'b1;
              if (left_q == 3'd1) begin
                if (pend_q == OPC_API) begin
                  lk_start = 1'b1;
                  state_d = S_LOOK;
                end else begin
                  cnt_d = '0;
                  ones_d = '0;
                  state_d = S_RED;
                end
              end
            end else if (b > 8'd7) begin
              err_d = ST_BADOP;
            end else if (operand_len(b[2:0]) == 3'd0) begin
              pend_d = b[2:0];
              if (b[2:0] == OPC_NOT) begin
                if (level_q == '0) err_d = ST_UNDER;
                else state_d = S_NOTR;
              end else begin
                pbit_d = (b[2:0] == OPC_UNK) ? unk_q : (b[2:0] == OPC_TRUE);
                state_d = S_PUSH;
              end
            end else begin
              pend_d = b[2:0];
              left_d = operand_len(b[2:0]);
              gather_d = '0;
            end
          end
          if (!in_i.data.last_byte && state_d == S_DONE) state_d = S_IDLE;
        end
      end
      S_LOOK: begin
        if (lk_done) begin
          pbit_d = lk_found;
          state_d = S_PUSH;
        end
      end
      S_RED: begin
        // One bit read per cycle from the stack top downward.
        if ({1'b0, n16} > {{(17-LW){1'b0}}, level_q} && cnt_q == '0 && !rdv_q) begin
          err_d = ST_UNDER;
          state_d = S_DONE;
        end else begin
          if (rdv_q) ones_d = ones_q + {16'd0, srd_q};
          if (cnt_q < {1'b0, n16}) begin
            sra = SAW'(level_q - 1'b1);
            rdv_d = 1'b1;
            level_d = level_q - 1'b1;
            cnt_d = cnt_q + 1'b1;
          end else if (!rdv_q) begin
            unique case (pend_q)
              OPC_AND: pbit_d = (ones_q == {1'b0, n16});
              OPC_OR:  pbit_d = (ones_q != '0);
              default: pbit_d = (ones_q >= {1'b0, k16});
            endcase
            state_d = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        if (level_q >= Depth) err_d = ST_OVER;
        else begin
          swe = 1'b1;
          swd = pbit_q;
          level_d = level_q + 1'b1;
        end
        state_d = S_DONE;
      end
      S_NOTR: begin
        // Read issued last cycle lands now; write the inverted top back.
        if (!ov_q) begin
          ov_d = 1'b1;
        end else begin
          swe = 1'b1;
          swa = SAW'(level_q - 1'b1);
          swd = ~srd_q;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        fin = last_q;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // The NOT read needs an address setup step, so its flag is cleared on entry.
    if (state_q == S_IDLE && state_d == S_NOTR) ov_d = 1'b0;
    if (fin) begin
      res_d.status = (err_q == ST_OK && left_q != 3'd0) ? ST_TRUNC : err_q;
      if (res_d.status == ST_OK && level_q != LW'(1)) res_d.status = ST_DEPTH;
      res_d.match = (res_d.status == ST_OK) && bot_q;
      level_d = '0; pend_d = '0; left_d = '0; gather_d = '0; err_d = ST_OK;
    end
  end

  logic ovalid_q;
  assign out_o.valid = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; level_q <= '0; pend_q <= '0; left_q <= '0;
      gather_q <= '0; err_q <= ST_OK; last_q <= 1'b0; cnt_q <= '0;
      ones_q <= '0; rdv_q <= 1'b0; ov_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; level_q <= level_d; pend_q <= pend_d; left_q <= left_d;
      gather_q <= gather_d; err_q <= err_d; last_q <= last_d; cnt_q <= cnt_d;
      ones_q <= ones_d; rdv_q <= rdv_d; ov_q <= ov_d;
      if (fin) ovalid_q <= 1'b1;
      else if (out_o.ready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pbit_q <= pbit_d;
    res_q <= res_d;
  end

  logic unused;
  assign unused = lk_busy ^ pwdata[31] ^ (|pwdata[30:1]);
endmodule

// ===== sim/brbe_scoreboard.sv =====
`timescale 1ns / 1ps
// Tracks the rule program state and holds the results that are still owed.
class brbe_scoreboard;
  localparam int unsigned DEPTH = 256;
  localparam int unsigned ENTRIES = 64;

  bit                    stack_bits[DEPTH];
  int unsigned           level;
  logic [31:0]           ids[ENTRIES];
  int unsigned           id_count;
  logic [2:0]            opcode;
  int unsigned           owed;
  logic [31:0]           gather;
  brbe_pkg::status_e     err;
  bit                    unk;
  brbe_pkg::out_item_t   pending_results[$];
  int                    mismatches;

  function void clear_program();
    level = 0;
    opcode = 3'd0;
    owed = 0;
    gather = '0;
    err = brbe_pkg::ST_OK;
  endfunction

  function int unsigned arg_bytes(logic [2:0] opc);
    if (opc == brbe_pkg::OPC_API || opc == brbe_pkg::OPC_NOF) return 4;
    if (opc == brbe_pkg::OPC_AND || opc == brbe_pkg::OPC_OR) return 2;
    return 0;
  endfunction

  function brbe_pkg::status_e push(bit v);
    if (level >= DEPTH) return brbe_pkg::ST_OVER;
    stack_bits[level] = v;
    level++;
    return brbe_pkg::ST_OK;
  endfunction

  function brbe_pkg::status_e run_op(logic [2:0] opc, logic [31:0] arg);
    int unsigned n;
    int unsigned k;
    int unsigned ones;
    bit hit;
    case (opc)
      brbe_pkg::OPC_API: begin
        hit = 0;
        for (int i = 0; i < id_count; i++) if (ids[i] == arg) hit = 1;
        return push(hit);
      end
      brbe_pkg::OPC_UNK: return push(unk);
      brbe_pkg::OPC_TRUE: return push(1'b1);
      brbe_pkg::OPC_FALSE: return push(1'b0);
      brbe_pkg::OPC_NOT: begin
        if (level == 0) return brbe_pkg::ST_UNDER;
        stack_bits[level-1] = !stack_bits[level-1];
        return brbe_pkg::ST_OK;
      end
      default: ;
    endcase
    if (opc == brbe_pkg::OPC_NOF) begin
      k = arg[15:0];
      n = arg[31:16];
    end else begin
      k = 0;
      n = arg[15:0];
    end
    if (n > level) return brbe_pkg::ST_UNDER;
    ones = 0;
    for (int unsigned i = level - n; i < level; i++) ones += stack_bits[i];
    level -= n;
    if (opc == brbe_pkg::OPC_AND) return push(ones == n);
    if (opc == brbe_pkg::OPC_OR) return push(ones != 0);
    return push(ones >= k);
  endfunction

  // Notes one accepted input transaction and queues its result, if any.
  function void note_input(brbe_pkg::in_item_t it);
    brbe_pkg::out_item_t r;
    int unsigned pos;
    if (it.operation == brbe_pkg::OPN_ADD) begin
      if (id_count < ENTRIES) begin
        ids[id_count] = it.api_id;
        id_count++;
      end
      return;
    end
    if (it.operation == brbe_pkg::OPN_CLEAR) begin
      id_count = 0;
      return;
    end
    if (it.operation == brbe_pkg::OPN_NONE) return;
    if (err == brbe_pkg::ST_OK) begin
      if (owed > 0) begin
        pos = arg_bytes(opcode) - owed;
        gather |= 32'(it.program_byte) << (8 * pos);
        owed--;
        if (owed == 0) err = run_op(opcode, gather);
      end else if (it.program_byte > 8'd7) begin
        err = brbe_pkg::ST_BADOP;
      end else if (arg_bytes(it.program_byte[2:0]) == 0) begin
        err = run_op(it.program_byte[2:0], '0);
      end else begin
        opcode = it.program_byte[2:0];
        owed = arg_bytes(opcode);
        gather = '0;
      end
    end
    if (!it.last_byte) return;
    if (err == brbe_pkg::ST_OK && owed > 0) err = brbe_pkg::ST_TRUNC;
    r.status = err;
    if (err == brbe_pkg::ST_OK && level != 1) r.status = brbe_pkg::ST_DEPTH;
    r.match = (r.status == brbe_pkg::ST_OK) ? stack_bits[0] : 1'b0;
    pending_results = {pending_results, r};
    clear_program();
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  // Compares one accepted result with the oldest expectation.
  task check_result(brbe_pkg::out_item_t got);
    brbe_pkg::out_item_t exp;
    if (pending_results.size() == 0) begin
      report($sformatf("unexpected result match=%0d status=%0d", got.match, got.status));
      return;
    end
    exp = pending_results.pop_front();
    if (got.match !== exp.match)
      report($sformatf("match got %b want %b", got.match, exp.match));
    if (got.status !== exp.status)
      report($sformatf("status got %0d want %0d", got.status, exp.status));
  endtask

  function new();
    id_count = 0;
    unk = 0;
    mismatches = 0;
    clear_program();
  endfunction
endclass

// ===== sim/boolean_rule_bytecode_evaluator_test.sv =====
`timescale 1ns / 1ps
module boolean_rule_bytecode_evaluator_test;
  import brbe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1500000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  brbe_in_if  in_ch ();
  brbe_out_if out_ch ();

  boolean_rule_bytecode_evaluator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  brbe_scoreboard sb;
  int unsigned    cycles = 0;
  bit             sender_idles;
  bit             receiver_idles;
  int unsigned    long_holds_asked = 0;
  int unsigned    long_holds_done = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog on the overall run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, and a long hold-off counted here on request.
  initial begin
    int unsigned gap;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (long_holds_done != long_holds_asked) begin
        long_holds_done++;
        out_ch.ready <= 1'b0;
        repeat (3000) @(negedge clk_i);
      end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 16);
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Every accepted transaction goes through the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) sb.note_input(in_ch.data);
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // Offers one transaction; valid stays high until the next one or an idle stretch.
  task automatic send(logic [1:0] opn, logic [7:0] b, logic lst, logic [31:0] id);
    int unsigned gap;
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{operation: opn, program_byte: b, last_byte: lst, api_id: id};
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic prog(logic [7:0] b, logic lst = 1'b0);
    send(OPN_PROG, b, lst, $urandom);
  endtask

  task automatic prog_op(opc_e c, logic lst = 1'b0);
    prog({5'd0, c}, lst);
  endtask

  task automatic prog_u16(logic [15:0] v);
    prog(v[7:0]);
    prog(v[15:8]);
  endtask

  task automatic prog_u32(logic [31:0] v);
    for (int i = 0; i < 4; i++) prog(v[8*i +: 8]);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
  endtask

  task automatic write_unknown(bit v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_UNKNOWN_VALUE[1:0];
    pwdata <= 32'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.unk = v;
  endtask

  // One random rule, usually folded to one bit at the last byte.
  task automatic random_rule(int unsigned ops);
    int unsigned depth;
    int unsigned n;
    int unsigned pick;
    logic [31:0] id;
    depth = 0;
    for (int unsigned i = 0; i < ops; i++) begin
      pick = $urandom_range(0, 9);
      if (depth == 0 || pick < 4) begin
        pick = $urandom_range(0, 3);
        if (pick == 0) begin
          id = (sb.id_count > 0 && $urandom_range(0, 1)) ?
               sb.ids[$urandom_range(0, sb.id_count - 1)] : $urandom;
          prog_op(OPC_API);
          prog_u32(id);
        end else begin
          prog(8'(pick));
        end
        depth++;
      end else if (pick < 6) begin
        prog_op(OPC_NOT);
      end else begin
        n = $urandom_range(0, depth);
        if (pick == 9) begin
          prog_op(OPC_NOF);
          prog_u16(16'($urandom_range(0, n + 1)));
          prog_u16(16'(n));
        end else begin
          prog_op(pick == 7 ? OPC_AND : OPC_OR);
          prog_u16(16'(n));
        end
        depth = depth - n + 1;
      end
    end
    // Usually fold to one bit; sometimes leave the depth wrong.
    if (depth > 0 && $urandom_range(0, 4) != 0) begin
      prog_op(OPC_OR);
      prog(8'(depth));
      prog(8'(depth >> 8), 1'b1);
    end else begin
      prog(8'($urandom_range(0, 3)), 1'b1);
    end
  endtask

  initial begin
    sb = new();
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: each opcode, operands at extremes, every status.
    write_unknown(1'b1);
    send(OPN_ADD, 8'd0, 1'b0, 32'hFFFF_FFFF);
    send(OPN_ADD, 8'd0, 1'b0, 32'h0000_0000);
    prog_op(OPC_API); prog_u32(32'hFFFF_FFFF);
    prog_op(OPC_UNK);
    prog_op(OPC_AND); prog_u16(16'd2);
    prog_op(OPC_NOT, 1'b1);
    prog_op(OPC_TRUE); prog_op(OPC_FALSE);
    prog_op(OPC_NOF); prog_u16(16'd1); prog_u16(16'd2);
    send(OPN_NONE, 8'hFF, 1'b1, 32'h0);
    prog_op(OPC_OR); prog_u16(16'd0);
    prog_op(OPC_AND, 1'b1);
    prog_op(OPC_NOT, 1'b1);
    prog(8'hFF); prog_op(OPC_TRUE, 1'b1);
    prog(8'd8, 1'b1);
    prog_op(OPC_FALSE); prog_op(OPC_FALSE, 1'b1);
    send(OPN_CLEAR, 8'd0, 1'b0, 32'h0);
    prog_op(OPC_API); prog_u32(32'h0);
    prog_op(OPC_AND); prog_u16(16'hFFFF); prog_op(OPC_TRUE, 1'b1);
    write_unknown(1'b0);
    prog_op(OPC_UNK, 1'b1);

    // Overflow: fill the stack, then an empty AND pushes one more bit.
    for (int i = 0; i < 256; i++) prog_op(OPC_TRUE);
    prog_op(OPC_AND); prog(8'd0); prog(8'd0, 1'b1);

    // Fill the present set past its size.
    for (int i = 0; i < 66; i++) send(OPN_ADD, 8'd0, 1'b0, $urandom_range(0, 40));

    // Long receiver hold-off while programs keep arriving.
    long_holds_asked++;
    for (int i = 0; i < 8; i++) prog_op(OPC_TRUE, 1'b1);
    // Sender waits until all results are in.
    drain();

    // Random phase.
    for (int r = 0; r < 7; r++) begin
      if (r == 2) write_unknown(1'b1);
      if (r == 4) write_unknown(1'b0);
      if (r == 5) begin
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
      end
      case ($urandom_range(0, 9))
        0: send(OPN_CLEAR, 8'($urandom), 1'($urandom), $urandom);
        1: send(OPN_ADD, 8'($urandom), 1'($urandom), $urandom_range(0, 40));
        2: begin
          for (int i = 0; i < 6; i++)
            send(OPN_PROG, 8'($urandom), $urandom_range(0, 5) == 0, $urandom);
          prog(8'($urandom), 1'b1);
        end
        3: send(OPN_NONE, 8'($urandom), 1'($urandom), $urandom);
        default: ;
      endcase
      random_rule($urandom_range(1, 6));
      if (r % 3 == 0) send(OPN_ADD, 8'd0, 1'b0, $urandom);
    end

    drain();
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
